/* hw/rtl/mbp_pkg.sv */
// ----------------------------------------------------------------------------
// mbp_pkg: shared types and constants of the MSB-first bit packer
// Command codes, field widths, byte buffer layout and the queue entry type
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package mbp_pkg;

  // Field and counter widths
  localparam int unsigned FieldW       = 64;
  localparam int unsigned LenW         = 7;
  localparam int unsigned CountW       = 48;
  localparam int unsigned MaxFieldBits = 64;

  // Byte buffer: partial byte followed by one full field
  localparam int unsigned BufBytes  = FieldW / 8 + 1;
  localparam int unsigned ByteCntW  = $clog2(BufBytes);
  localparam int unsigned MaxBytes  = (MaxFieldBits + 7) / 8;
  localparam int unsigned IdxW      = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CmdAppend = 2'd0,
    CmdAlign  = 2'd1,
    CmdFlush  = 2'd2
  } cmd_e;

  typedef logic [BufBytes-1:0][7:0] byte_buf_t;

  // One queued item: bytes in emit order from the top, count, running total
  typedef struct packed {
    byte_buf_t             bytes;
    logic [ByteCntW-1:0]   nbytes;
    logic [CountW-1:0]     total;
  } entry_t;

endpackage

/* hw/rtl/mbp_front.sv */
// ----------------------------------------------------------------------------
// mbp_front: command decode and bit packing state
// Merges each field into the pending partial byte, updates the running bit
// count and posts every item that completes bytes to the queue.
// ----------------------------------------------------------------------------
module mbp_front
  import mbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [1:0]        cmd_i,
  input  logic [FieldW-1:0] field_value_i,
  input  logic [LenW-1:0]   field_length_i,
  output logic              push_o,
  output entry_t            entry_o
);

  logic [7:0]          partial_q, partial_d;
  logic [2:0]          fill_q, fill_d;
  logic [CountW-1:0]   count_q, count_d;

  logic                accept;
  logic [LenW-1:0]     len_sat;
  logic [FieldW-1:0]   aligned;
  byte_buf_t           buf_word;
  logic [LenW:0]       bit_sum;
  logic [ByteCntW-1:0] nbytes;
  logic [ByteCntW-1:0] byte_sel;
  logic                emit;

  assign accept = in_valid_i && in_ready_i;

  // Saturate length and left-justify the field; bits above the length drop out
  assign len_sat  = (field_length_i > LenW'(MaxFieldBits)) ? LenW'(MaxFieldBits)
                                                            : field_length_i;
  assign aligned  = field_value_i << (LenW'(FieldW) - len_sat);
  assign buf_word = {partial_q, {FieldW{1'b0}}} | ({aligned, 8'h00} >> fill_q);
  assign bit_sum  = (LenW+1)'(fill_q) + (LenW+1)'(len_sat);
  assign nbytes   = ByteCntW'(bit_sum >> 3);
  assign byte_sel = ByteCntW'(BufBytes - 1) - nbytes;

  // Decode the command into next state and queue entry
  always_comb begin
    partial_d      = partial_q;
    fill_d         = fill_q;
    count_d        = count_q;
    emit           = 1'b0;
    entry_o.bytes  = buf_word;
    entry_o.nbytes = nbytes;
    unique case (cmd_e'(cmd_i))
      CmdAppend: begin
        partial_d = buf_word[byte_sel];
        fill_d    = bit_sum[2:0];
        count_d   = count_q + CountW'(len_sat);
        emit      = (nbytes != '0);
      end
      CmdAlign: begin
        entry_o.bytes  = {partial_q, {FieldW{1'b0}}};
        entry_o.nbytes = ByteCntW'(1);
        if (fill_q != 3'd0) begin
          emit      = 1'b1;
          partial_d = 8'h00;
          fill_d    = 3'd0;
          count_d   = count_q + CountW'(4'd8 - {1'b0, fill_q});
        end
      end
      CmdFlush: begin
        entry_o.bytes  = {partial_q, {FieldW{1'b0}}};
        entry_o.nbytes = ByteCntW'(1);
        if (fill_q != 3'd0) begin
          emit      = 1'b1;
          partial_d = 8'h00;
          fill_d    = 3'd0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    entry_o.total = count_d;
  end

  assign push_o = accept && emit;

  // Advance packing state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 8'h00;
      fill_q    <= 3'd0;
      count_q   <= '0;
    end else if (accept) begin
      partial_q <= partial_d;
      fill_q    <= fill_d;
      count_q   <= count_d;
    end
  end

endmodule

/* hw/rtl/mbp_queue.sv */
// ----------------------------------------------------------------------------
// mbp_queue: short item queue between front and back end
// Two-entry FIFO of packed items; lets each side stall on its own.
// ----------------------------------------------------------------------------
module mbp_queue
  import mbp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   ready_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;

  assign ready_o = (count_q != (PtrW+1)'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/mbp_back.sv */
// ----------------------------------------------------------------------------
// mbp_back: byte emitter
// Walks the bytes of the queue head into an output register one per cycle
// while the output is not stalled, and marks the final byte of each item.
// ----------------------------------------------------------------------------
module mbp_back
  import mbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  entry_t            head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic [CountW-1:0] bit_total_o
);

  logic [IdxW-1:0]     idx_q, idx_d;
  logic                valid_q, valid_d;
  logic [7:0]          byte_q;
  logic                last_q;
  logic [CountW-1:0]   total_q;

  logic                load;
  logic                is_last;
  logic [ByteCntW-1:0] sel;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = ((ByteCntW'(idx_q) + 1'b1) == head_i.nbytes);
  assign sel     = ByteCntW'(BufBytes - 1) - ByteCntW'(idx_q);
  assign pop_o   = load && is_last;

  // Next byte index and output valid
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  // Hold the output payload until the next load
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= head_i.bytes[sel];
      last_q  <= is_last;
      total_q <= head_i.total;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;
  assign bit_total_o   = total_q;

endmodule

/* hw/rtl/msb_first_bit_packer.sv */
// ----------------------------------------------------------------------------
// Path: an item is queued, then each of its bytes is registered at the output.
// Throughput: one item per cycle in while the queue has room; one byte per
// cycle out while not stalled; an item of k bytes holds the emitter for all k.
// Reset: asynchronous, clears the partial byte, fill count, bit count, queue
// occupancy, output valid and byte index; no clearing pass.
// ----------------------------------------------------------------------------
// msb_first_bit_packer: MSB-first bit field packer, top level
// Front end packs fields into bytes, a two-entry queue decouples it from the
// back end, which emits completed bytes with the running bit count.
// ----------------------------------------------------------------------------
module msb_first_bit_packer
  import mbp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [FieldW-1:0] field_value_i,
  input  logic [LenW-1:0]   field_length_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_of_run_o,
  output logic [CountW-1:0] bit_total_o
);

  logic   push;
  entry_t push_data;
  logic   pop;
  logic   head_valid;
  entry_t head;

  mbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .cmd_i          (cmd_i),
    .field_value_i  (field_value_i),
    .field_length_i (field_length_i),
    .push_o         (push),
    .entry_o        (push_data)
  );

  mbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (in_ready_o),
    .pop_i       (pop),
    .valid_o     (head_valid),
    .head_o      (head)
  );

  mbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .bit_total_o   (bit_total_o)
  );

endmodule

/* hw/rtl/mbp_checker.sv */
// ----------------------------------------------------------------------------
// mbp_checker: port-level checks for the bit packer
// Watches the output channel and input readiness over time.
// ----------------------------------------------------------------------------
module mbp_checker
  import mbp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [7:0]        out_byte_o,
  input logic              last_of_run_o,
  input logic [CountW-1:0] bit_total_o
);

  // Hold a stalled result with its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) &&
      $stable(last_of_run_o) && $stable(bit_total_o))
    else $error("stalled result changed");

  // Bytes of one run follow back to back with the same bit total
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_run_o |=> out_valid_o &&
      $stable(bit_total_o))
    else $error("run broken or bit total changed inside a run");

  // An output that stays idle implies the queue has room, so the input is ready
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && $past(!out_valid_o) |-> in_ready_o)
    else $error("input stalled while output stayed idle");

endmodule

bind msb_first_bit_packer mbp_checker u_mbp_checker (.*);
